FILE: rtl/local_alignment_span_defines.svh
// Assertion macros shared by the local alignment span design.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef LOCAL_ALIGNMENT_SPAN_DEFINES_SVH
`define LOCAL_ALIGNMENT_SPAN_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LAS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LAS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/las_pkg.sv
// Package for the local alignment span block: sizes, codes and transaction types.
// Has no dependencies.
package las_pkg;

   localparam int MAX_LEN     = 256;
   localparam int SCORE_BITS  = 12;
   localparam int LEN_BITS    = $clog2(MAX_LEN + 1);
   localparam int IDX_BITS    = $clog2(MAX_LEN);
   localparam int TRACE_DEPTH = 1 << (2 * IDX_BITS);
   localparam int SYM_BITS    = 8;
   localparam int CFG_BITS    = 4;
   localparam int CSR_IDX_BITS = 2;
   localparam int MARK_BITS   = 2;

   localparam logic [1:0] CMD_APPEND_FIRST  = 2'd0;
   localparam logic [1:0] CMD_APPEND_SECOND = 2'd1;
   localparam logic [1:0] CMD_ALIGN         = 2'd2;
   localparam logic [1:0] CMD_IGNORED       = 2'd3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MATCH_BONUS   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MISMATCH_COST = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GAP_COST      = 2'd2;

   localparam logic [MARK_BITS-1:0] MARK_STOP   = 2'd0;
   localparam logic [MARK_BITS-1:0] MARK_DIAG   = 2'd1;
   localparam logic [MARK_BITS-1:0] MARK_FIRST  = 2'd2;
   localparam logic [MARK_BITS-1:0] MARK_SECOND = 2'd3;

   typedef struct packed {
      logic [1:0]          command;
      logic [SYM_BITS-1:0] symbol;
   } req_type;

   typedef struct packed {
      logic [LEN_BITS-1:0]   second_start;
      logic [LEN_BITS-1:0]   second_end;
      logic [SCORE_BITS-1:0] best_score;
      logic                  overflow;
   } rsp_type;

   typedef struct packed {
      logic [SCORE_BITS-1:0] score;
      logic [MARK_BITS-1:0]  mark;
   } cell_type;

endpackage

FILE: rtl/las_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Has no dependencies.
module las_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/las_cell.sv
// Score of one matrix cell from its three neighbours, with the traceback mark.
// Depends on las_pkg.
module las_cell
   import las_pkg::*;
(
   input  logic [SCORE_BITS-1:0] diag_score,
   input  logic [SCORE_BITS-1:0] up_score,
   input  logic [SCORE_BITS-1:0] left_score,
   input  logic                  symbols_equal,
   input  logic [CFG_BITS-1:0]   match_bonus,
   input  logic [CFG_BITS-1:0]   mismatch_cost,
   input  logic [CFG_BITS-1:0]   gap_cost,
   output cell_type              node
);

   localparam logic [SCORE_BITS:0] SCORE_MAX = {1'b0, {SCORE_BITS{1'b1}}};

   logic [SCORE_BITS:0]   diag_sum;
   logic [SCORE_BITS-1:0] cand_diag;
   logic [SCORE_BITS-1:0] cand_up;
   logic [SCORE_BITS-1:0] cand_left;
   logic [SCORE_BITS-1:0] best;

   always_comb begin
      diag_sum = {1'b0, diag_score} + (SCORE_BITS + 1)'(match_bonus);
      if (symbols_equal) begin
         cand_diag = (diag_sum > SCORE_MAX) ? SCORE_MAX[SCORE_BITS-1:0]
                                            : diag_sum[SCORE_BITS-1:0];
      end else begin
         cand_diag = (diag_score >= SCORE_BITS'(mismatch_cost))
                   ? diag_score - SCORE_BITS'(mismatch_cost) : '0;
      end
      cand_up   = (up_score >= SCORE_BITS'(gap_cost)) ? up_score - SCORE_BITS'(gap_cost) : '0;
      cand_left = (left_score >= SCORE_BITS'(gap_cost))
                ? left_score - SCORE_BITS'(gap_cost) : '0;

      best = cand_diag;
      if (cand_up > best) begin
         best = cand_up;
      end
      if (cand_left > best) begin
         best = cand_left;
      end

      node.score = best;
      if (best == '0) begin
         node.mark = MARK_STOP;
      end else if (best == cand_diag) begin
         node.mark = MARK_DIAG;
      end else if (best == cand_up) begin
         node.mark = MARK_FIRST;
      end else begin
         node.mark = MARK_SECOND;
      end
   end

endmodule

FILE: rtl/local_alignment_span.sv
// Top level of the local alignment span block: sequence stores, matrix sweep and traceback.
// Depends on las_pkg, las_ram, las_cell and local_alignment_span_defines.svh.
//
// This block finds the best local alignment of two byte sequences under a linear gap cost.
// Each append transaction stores one symbol in the first or second sequence; while no
// alignment runs, symbols can stream in back to back; a symbol beyond 256 in a sequence is
// dropped and reported through the overflow bit of the next result. An align transaction
// sweeps the score matrix row by row and then traces back from the best cell; it produces
// one result transaction and empties both sequences. Each cell of the sweep takes a read
// state and a calculate state, each row a start and a wait state, and each traceback step a
// read and a check state, since the score row memory and the trace memory each have one
// registered read port, and every cell reads, updates and writes back one row entry. While
// an alignment runs the request side is stalled. A finished result waits in an output
// register, and new append transactions are accepted while it waits. Configuration
// registers should be written only while no alignment is in progress.
`include "local_alignment_span_defines.svh"

module local_alignment_span
   import las_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]     csr_wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_ROW_START, ST_ROW_WAIT, ST_CELL_RD, ST_CELL_CALC,
      ST_TB_RD, ST_TB_CHK, ST_DONE
   } state_type;

   state_type state_ff;

   logic [CFG_BITS-1:0]   match_bonus_ff, mismatch_cost_ff, gap_cost_ff;
   logic [LEN_BITS-1:0]   len1_ff, len2_ff, n1_ff, n2_ff;
   logic                  drop_ff, ovf_ff;
   logic [LEN_BITS-1:0]   i_ff, j_ff, bi_ff, bj_ff;
   logic [SCORE_BITS-1:0] diag_ff, left_ff, best_ff;
   logic [SYM_BITS-1:0]   sym1_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  req_fire;
   logic [LEN_BITS-1:0]   i_m1, j_m1;
   logic [SYM_BITS-1:0]   seq1_rd, seq2_rd;
   logic [SCORE_BITS-1:0] row_rd, up_score;
   logic [MARK_BITS-1:0]  trace_rd;
   logic                  seq1_we, seq2_we, calc;
   cell_type              node;

   // Requests are taken only while no alignment is in progress.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign i_m1 = i_ff - LEN_BITS'(1);
   assign j_m1 = j_ff - LEN_BITS'(1);
   assign calc = (state_ff == ST_CELL_CALC);

   assign seq1_we = req_fire && (req_data.command == CMD_APPEND_FIRST) &&
                    (len1_ff != LEN_BITS'(MAX_LEN));
   assign seq2_we = req_fire && (req_data.command == CMD_APPEND_SECOND) &&
                    (len2_ff != LEN_BITS'(MAX_LEN));

   // The first row of the sweep sees an all-zero row above it, so the row memory
   // is never cleared: its contents are ignored while the row index is one.
   assign up_score = (i_ff == LEN_BITS'(1)) ? '0 : row_rd;

   las_ram #(.WIDTH(SYM_BITS), .DEPTH(MAX_LEN)) u_seq1 (
      .clock   (clock),
      .wr_en   (seq1_we),
      .wr_addr (len1_ff[IDX_BITS-1:0]),
      .wr_data (req_data.symbol),
      .rd_addr (i_m1[IDX_BITS-1:0]),
      .rd_data (seq1_rd)
   );

   las_ram #(.WIDTH(SYM_BITS), .DEPTH(MAX_LEN)) u_seq2 (
      .clock   (clock),
      .wr_en   (seq2_we),
      .wr_addr (len2_ff[IDX_BITS-1:0]),
      .wr_data (req_data.symbol),
      .rd_addr (j_m1[IDX_BITS-1:0]),
      .rd_data (seq2_rd)
   );

   // One row of scores: entry j-1 holds the row above until the cell below overwrites it.
   las_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_LEN)) u_row (
      .clock   (clock),
      .wr_en   (calc),
      .wr_addr (j_m1[IDX_BITS-1:0]),
      .wr_data (node.score),
      .rd_addr (j_m1[IDX_BITS-1:0]),
      .rd_data (row_rd)
   );

   las_ram #(.WIDTH(MARK_BITS), .DEPTH(TRACE_DEPTH)) u_trace (
      .clock   (clock),
      .wr_en   (calc),
      .wr_addr ({i_m1[IDX_BITS-1:0], j_m1[IDX_BITS-1:0]}),
      .wr_data (node.mark),
      .rd_addr ({i_m1[IDX_BITS-1:0], j_m1[IDX_BITS-1:0]}),
      .rd_data (trace_rd)
   );

   las_cell u_cell (
      .diag_score    (diag_ff),
      .up_score      (up_score),
      .left_score    (left_ff),
      .symbols_equal (sym1_ff == seq2_rd),
      .match_bonus   (match_bonus_ff),
      .mismatch_cost (mismatch_cost_ff),
      .gap_cost      (gap_cost_ff),
      .node          (node)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         match_bonus_ff   <= CFG_BITS'(1);
         mismatch_cost_ff <= CFG_BITS'(6);
         gap_cost_ff      <= CFG_BITS'(1);
         len1_ff          <= '0;
         len2_ff          <= '0;
         drop_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MATCH_BONUS:   match_bonus_ff   <= csr_wr_data;
               CSR_MISMATCH_COST: mismatch_cost_ff <= csr_wr_data;
               CSR_GAP_COST:      gap_cost_ff      <= csr_wr_data;
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (req_data.command)
                     CMD_APPEND_FIRST: begin
                        if (seq1_we) begin
                           len1_ff <= len1_ff + LEN_BITS'(1);
                        end else begin
                           drop_ff <= 1'b1;
                        end
                     end
                     CMD_APPEND_SECOND: begin
                        if (seq2_we) begin
                           len2_ff <= len2_ff + LEN_BITS'(1);
                        end else begin
                           drop_ff <= 1'b1;
                        end
                     end
                     CMD_ALIGN: begin
                        // Latch the job and empty the sequences at once.
                        n1_ff   <= len1_ff;
                        n2_ff   <= len2_ff;
                        ovf_ff  <= drop_ff;
                        len1_ff <= '0;
                        len2_ff <= '0;
                        drop_ff <= 1'b0;
                        best_ff <= '0;
                        bi_ff   <= '0;
                        bj_ff   <= '0;
                        i_ff    <= LEN_BITS'(1);
                        if (len1_ff == '0 || len2_ff == '0) begin
                           state_ff <= ST_DONE;
                           j_ff     <= '0;
                        end else begin
                           state_ff <= ST_ROW_START;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_ROW_START: begin
               state_ff <= ST_ROW_WAIT;
            end
            ST_ROW_WAIT: begin
               sym1_ff  <= seq1_rd;
               diag_ff  <= '0;
               left_ff  <= '0;
               j_ff     <= LEN_BITS'(1);
               state_ff <= ST_CELL_RD;
            end
            ST_CELL_RD: begin
               state_ff <= ST_CELL_CALC;
            end
            ST_CELL_CALC: begin
               diag_ff <= up_score;
               left_ff <= node.score;
               if (node.score > best_ff) begin
                  best_ff <= node.score;
                  bi_ff   <= i_ff;
                  bj_ff   <= j_ff;
               end
               if (j_ff != n2_ff) begin
                  j_ff     <= j_ff + LEN_BITS'(1);
                  state_ff <= ST_CELL_RD;
               end else if (i_ff != n1_ff) begin
                  i_ff     <= i_ff + LEN_BITS'(1);
                  state_ff <= ST_ROW_START;
               end else begin
                  state_ff <= ST_TB_RD;
                  if (node.score > best_ff) begin
                     i_ff <= i_ff;
                     j_ff <= j_ff;
                  end else begin
                     i_ff <= bi_ff;
                     j_ff <= bj_ff;
                  end
               end
            end
            ST_TB_RD: begin
               // A zero best score leaves both indices at zero, which ends here.
               if (i_ff == '0 || j_ff == '0) begin
                  state_ff <= ST_DONE;
               end else begin
                  state_ff <= ST_TB_CHK;
               end
            end
            ST_TB_CHK: begin
               case (trace_rd)
                  MARK_STOP: begin
                     state_ff <= ST_DONE;
                  end
                  MARK_DIAG: begin
                     i_ff     <= i_m1;
                     j_ff     <= j_m1;
                     state_ff <= ST_TB_RD;
                  end
                  MARK_FIRST: begin
                     i_ff     <= i_m1;
                     state_ff <= ST_TB_RD;
                  end
                  default: begin
                     j_ff     <= j_m1;
                     state_ff <= ST_TB_RD;
                  end
               endcase
            end
            ST_DONE: begin
               if (!rsp_valid_ff) begin
                  rsp_ff.second_start <= j_ff;
                  rsp_ff.second_end   <= bj_ff;
                  rsp_ff.best_score   <= best_ff;
                  rsp_ff.overflow     <= ovf_ff;
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `LAS_ASSERT_NEXT(a_align_starts, req_fire && (req_data.command == CMD_ALIGN), state_ff != ST_IDLE, "align transaction did not start a job")
   `LAS_ASSERT_SAME(a_zero_score_no_end, rsp_valid_ff && (rsp_ff.best_score == '0), rsp_ff.second_end == '0, "zero score with a nonzero end")
   `LAS_ASSERT_SAME(a_cell_in_range, calc, (j_ff != '0) && (j_ff <= n2_ff) && (i_ff != '0) && (i_ff <= n1_ff), "cell index outside the matrix")
   `LAS_ASSERT_SAME(a_trace_bounded, state_ff == ST_TB_CHK, (j_ff <= bj_ff) && (i_ff <= bi_ff), "traceback moved past the best cell")

endmodule
